/* rtl/mks_pkg.sv */
// Shared types and constants for the matrix keypad scanner.
// No dependencies; imported by every module of the block.
package mks_pkg;

   localparam int KEY_ROWS    = 4;
   localparam int KEY_COLUMNS = 4;
   localparam int ROW_W       = 2;
   localparam int COL_W       = 2;
   localparam int CODE_W      = 5;
   localparam int COUNT_W     = 16;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [15:0] IMMEDIATE_RESET = 16'd19008;

   // register indexes, taken from paddr[2]
   localparam logic REG_DEBOUNCE  = 1'b0;
   localparam logic REG_IMMEDIATE = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0] debounce_ticks;
      logic [15:0]        immediate_key_mask;
   } cfg_type;

   typedef struct packed {
      logic [KEY_COLUMNS-1:0] column_drive;
      logic                   key_valid;
      logic [CODE_W-1:0]      key_code;
   } rsp_type;

endpackage

/* rtl/matrix_keypad_scanner.sv */
// 4x4 matrix keypad scanner. Each req word carries the row levels read for the
// column driven now; each rsp word gives the column drive for the next tick, and
// a key code when a key event completes. One word is taken every clock cycle
// while req_stall is low: the whole scan/debounce update is combinational. A
// two-entry output buffer takes one more word while rsp is stalled; req_stall
// then rises on the next cycle and stays high until the buffer has a free entry
// again; rsp is driven from buffer registers. Registers: 0x0 debounce_ticks,
// 0x4 immediate_key_mask. Depends on mks_pkg, mks_scan_core and mks_skid.
module matrix_keypad_scanner import mks_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KEY_ROWS-1:0]    req_row_levels,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KEY_COLUMNS-1:0] rsp_column_drive,
   output logic                   rsp_key_valid,
   output logic [CODE_W-1:0]      rsp_key_code,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg_ff;
   rsp_type core_word;
   rsp_type out_word;
   logic    word_fire;
   logic    csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= DEBOUNCE_RESET;
         cfg_ff.immediate_key_mask <= IMMEDIATE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_DEBOUNCE:  cfg_ff.debounce_ticks     <= csr_pwdata[15:0];
            REG_IMMEDIATE: cfg_ff.immediate_key_mask <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_DEBOUNCE:  csr_prdata = {16'd0, cfg_ff.debounce_ticks};
         REG_IMMEDIATE: csr_prdata = {16'd0, cfg_ff.immediate_key_mask};
         default:       csr_prdata = '0;
      endcase
   end

   assign word_fire = req_valid && !req_stall;

   mks_scan_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .word_fire  (word_fire),
      .row_levels (req_row_levels),
      .result     (core_word)
   );

   mks_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (word_fire),
      .in_word   (core_word),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_word  (out_word),
      .out_stall (rsp_stall)
   );

   assign rsp_column_drive = out_word.column_drive;
   assign rsp_key_valid    = out_word.key_valid;
   assign rsp_key_code     = out_word.key_code;

   a_code_matches_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_key_valid && rsp_key_code != '0) ||
                     (!rsp_key_valid && rsp_key_code == '0)))
      else $error("key code does not match key_valid");

   a_one_column_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_column_drive) == 1)
      else $error("column drive does not have exactly one low line");

   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a stalled output word");

endmodule

/* rtl/mks_scan_core.sv */
// Scan and debounce state machine: one input word updates the state and
// yields one result word in the same cycle. Depends on mks_pkg.
module mks_scan_core import mks_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                word_fire,
   input  logic [KEY_ROWS-1:0] row_levels,
   output rsp_type             result
);

   typedef enum logic [1:0] {
      PH_SCAN    = 2'd0,
      PH_PRESS   = 2'd1,
      PH_RELEASE = 2'd2,
      PH_SETTLE  = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ROW_W-1:0]   held_ff, held_in;

   logic               found;
   logic [ROW_W-1:0]   hit;
   logic [COL_W-1:0]   column_next;
   logic [COUNT_W-1:0] count_dec;
   logic               count_done;

   always_comb begin
      found = 1'b0;
      hit   = '0;
      // last low row wins
      for (int r = 0; r < KEY_ROWS; r++) begin
         if (!row_levels[r]) begin
            found = 1'b1;
            hit   = ROW_W'(r);
         end
      end
   end

   assign column_next = (column_ff == COL_W'(KEY_COLUMNS - 1)) ? '0 : column_ff + 1'b1;
   assign count_dec   = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
   assign count_done  = (count_dec == '0);

   always_comb begin
      phase_in        = phase_ff;
      column_in       = column_ff;
      count_in        = count_ff;
      held_in         = held_ff;
      result.key_valid = 1'b0;
      result.key_code  = '0;
      case (phase_ff)
         PH_SCAN: begin
            if (!found) begin
               column_in = column_next;
            end else if (cfg.immediate_key_mask[{hit, column_ff}]) begin
               result.key_valid = 1'b1;
               result.key_code  = {1'b0, hit, column_ff} + 1'b1;
               column_in        = column_next;
            end else begin
               held_in  = hit;
               count_in = cfg.debounce_ticks;
               phase_in = PH_PRESS;
            end
         end
         PH_PRESS: begin
            count_in = count_dec;
            if (count_done) begin
               phase_in = PH_RELEASE;
            end
         end
         PH_RELEASE: begin
            if (row_levels[held_ff]) begin
               count_in = cfg.debounce_ticks;
               phase_in = PH_SETTLE;
            end
         end
         PH_SETTLE: begin
            count_in = count_dec;
            if (count_done) begin
               result.key_valid = 1'b1;
               result.key_code  = {1'b0, held_ff, column_ff} + 1'b1;
               phase_in         = PH_SCAN;
               column_in        = column_next;
            end
         end
         default: begin
            phase_in = PH_SCAN;
         end
      endcase
      result.column_drive = ~(KEY_COLUMNS'(1) << column_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SCAN;
         column_ff <= '0;
         count_ff  <= '0;
         held_ff   <= '0;
      end else if (word_fire) begin
         phase_ff  <= phase_in;
         column_ff <= column_in;
         count_ff  <= count_in;
         held_ff   <= held_in;
      end
   end

endmodule

/* rtl/mks_skid.sv */
// Two-entry output buffer: holds result words while the consumer stalls,
// with a registered stall back to the producer. Depends on mks_pkg.
module mks_skid import mks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_word,
   output logic    in_stall,
   output logic    out_valid,
   output rsp_type out_word,
   input  logic    out_stall
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    in_fire;

   assign in_stall  = skid_valid_ff;
   assign in_fire   = in_valid && !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_word;
            main_valid_in = in_fire;
         end
      end else if (in_fire) begin
         skid_in       = in_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

/* bench/keypad_scan_checker.sv */
// Checker for the keypad scanner: watches req, rsp and csr traffic, keeps its own
// scan/debounce state, predicts every rsp word and compares it field by field.
// Depends on mks_pkg.
module keypad_scan_checker import mks_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [KEY_ROWS-1:0]    req_row_levels,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [KEY_COLUMNS-1:0] rsp_column_drive,
   input  logic                   rsp_key_valid,
   input  logic [CODE_W-1:0]      rsp_key_code,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   input  logic                   csr_pready,
   output int                     fail_count,
   output int                     pending
);

   typedef enum logic [1:0] {SCANNING, PRESS_WAIT, RELEASE_WAIT, SETTLE_WAIT} scan_state_type;

   logic [COL_W-1:0]   scan_col;
   scan_state_type     scan_state;
   logic [COUNT_W-1:0] wait_left;
   logic [ROW_W-1:0]   held_row;
   logic [15:0]        deb_ticks;
   logic [15:0]        imm_mask;
   logic               found;
   logic [ROW_W-1:0]   hit_row;
   rsp_type            want;
   rsp_type            predicted_reports[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // Everything is sampled at the falling edge: inputs and block outputs only
   // move at the rising edge, so this sees what the next rising edge will take.
   always @(negedge clock) begin
      if (reset) begin
         scan_col = '0;
         scan_state = SCANNING;
         wait_left = '0;
         held_row = '0;
         deb_ticks = DEBOUNCE_RESET;
         imm_mask = IMMEDIATE_RESET;
         predicted_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               REG_DEBOUNCE:  deb_ticks = csr_pwdata[15:0];
               REG_IMMEDIATE: imm_mask = csr_pwdata[15:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               if (fail_count < 10)
                  $display("rsp word with nothing expected: drive %h valid %b code %0d",
                           rsp_column_drive, rsp_key_valid, rsp_key_code);
               fail_count++;
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_column_drive !== want.column_drive ||
                   rsp_key_valid !== want.key_valid ||
                   rsp_key_code !== want.key_code) begin
                  if (fail_count < 10)
                     $display({"rsp mismatch: expected drive %h valid %b code %0d,",
                               " got drive %h valid %b code %0d"},
                              want.column_drive, want.key_valid, want.key_code,
                              rsp_column_drive, rsp_key_valid, rsp_key_code);
                  fail_count++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            want = '0;
            case (scan_state)
               SCANNING: begin
                  found = 1'b0;
                  hit_row = '0;
                  // highest low row wins
                  for (int r = 0; r < KEY_ROWS; r++) begin
                     if (!req_row_levels[r]) begin
                        found = 1'b1;
                        hit_row = r[ROW_W-1:0];
                     end
                  end
                  if (!found) begin
                     scan_col = scan_col + 1'b1;
                  end else if (imm_mask[{hit_row, scan_col}]) begin
                     want.key_valid = 1'b1;
                     want.key_code = {1'b0, hit_row, scan_col} + 5'd1;
                     scan_col = scan_col + 1'b1;
                  end else begin
                     held_row = hit_row;
                     wait_left = deb_ticks;
                     scan_state = PRESS_WAIT;
                  end
               end
               PRESS_WAIT: begin
                  if (wait_left != 0)
                     wait_left = wait_left - 1'b1;
                  if (wait_left == 0)
                     scan_state = RELEASE_WAIT;
               end
               RELEASE_WAIT: begin
                  if (req_row_levels[held_row]) begin
                     wait_left = deb_ticks;
                     scan_state = SETTLE_WAIT;
                  end
               end
               SETTLE_WAIT: begin
                  if (wait_left != 0)
                     wait_left = wait_left - 1'b1;
                  if (wait_left == 0) begin
                     want.key_valid = 1'b1;
                     want.key_code = {1'b0, held_row, scan_col} + 5'd1;
                     scan_state = SCANNING;
                     scan_col = scan_col + 1'b1;
                  end
               end
               default: begin
                  scan_state = SCANNING;
               end
            endcase
            want.column_drive = '1;
            want.column_drive[scan_col] = 1'b0;
            predicted_reports.push_back(want);
         end
      end
      pending = predicted_reports.size();
   end

endmodule

/* bench/tb_matrix_keypad_scanner.sv */
// Top of the keypad scanner bench: clock, reset, row-level stimulus, rsp stalls
// and csr writes; the verdict comes from keypad_scan_checker.
// Depends on mks_pkg, keypad_scan_checker and the scanner RTL.
module tb_matrix_keypad_scanner;
   import mks_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT    = 34;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [KEY_ROWS-1:0]    req_row_levels;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KEY_COLUMNS-1:0] rsp_column_drive;
   logic                   rsp_key_valid;
   logic [CODE_W-1:0]      rsp_key_code;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [2:0]             csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int   fail_count;
   int   pending;
   int   words_sent = 0;
   int   cycle_count = 0;
   int   hold_count = 0;
   logic hold_done = 1'b0;
   logic pressure;
   logic idle_on;

   logic [KEY_ROWS-1:0] directed_rows [25] = '{
      4'hF, 4'hF, 4'hF, 4'hF, 4'hE, 4'hF, 4'hD, 4'hF, 4'hB, 4'hF, 4'h7, 4'hF, 4'h0,
      4'h0, 4'hF, 4'h6, 4'hF, 4'h9, 4'h9, 4'hF, 4'h3, 4'hF, 4'hC, 4'hF, 4'hF};

   matrix_keypad_scanner i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row_levels   (req_row_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_drive (rsp_column_drive),
      .rsp_key_valid    (rsp_key_valid),
      .rsp_key_code     (rsp_key_code),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   keypad_scan_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row_levels   (req_row_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_drive (rsp_column_drive),
      .rsp_key_valid    (rsp_key_valid),
      .rsp_key_code     (rsp_key_code),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // rsp side: random stalls, plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (pressure && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1)
            hold_done <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // stall is sampled at the falling edge, where it already holds its value
   // for the coming rising edge
   task automatic send_word(input logic [KEY_ROWS-1:0] rows);
      logic taken;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_levels <= rows;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      words_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      logic ready;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end while (!ready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // press, hold, release, with an occasional bounced word on either side
   task automatic key_event(input int press_len, input int release_len);
      logic [KEY_ROWS-1:0] press;
      press = KEY_ROWS'($urandom_range(14));
      repeat (press_len)
         send_word(($urandom_range(7) == 0) ? KEY_ROWS'($urandom_range(15)) : press);
      repeat (release_len)
         send_word(($urandom_range(7) == 0) ? KEY_ROWS'($urandom_range(15)) : '1);
   endtask

   task automatic run_phase(input logic [15:0] deb, input logic [15:0] mask,
                            input int count, input logic with_hold);
      int stop_at;
      wait_idle();
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_IMMEDIATE, mask);
      if (with_hold)
         pressure <= 1'b1;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 6)) send_word(KEY_ROWS'($urandom_range(15)));
         else
            key_event($urandom_range(1, deb + 4), $urandom_range(1, deb + 4));
      end
      // all lines high long enough that any debounce in flight finishes
      repeat (2 * deb + 4) send_word('1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_row_levels = '1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      pressure = 1'b0;
      idle_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_DEBOUNCE, 16'd0);
      foreach (directed_rows[i])
         send_word(directed_rows[i]);

      run_phase(DEBOUNCE_RESET, IMMEDIATE_RESET, 150, 1'b0);
      idle_on = 1'b0;
      run_phase(16'd0, 16'h0000, 200, 1'b0);
      idle_on = 1'b1;
      run_phase(16'd3, 16'hFFFF, 200, 1'b0);
      run_phase(16'd1, 16'($urandom_range(65535)), 250, 1'b0);
      run_phase(16'd5, 16'($urandom_range(65535)), 250, 1'b1);

      // long debounce: one full press/release cycle
      wait_idle();
      write_reg(REG_DEBOUNCE, 16'd100);
      write_reg(REG_IMMEDIATE, 16'h0000);
      key_event(103, 103);

      wait_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/mks_pkg.sv
rtl/mks_scan_core.sv
rtl/mks_skid.sv
rtl/matrix_keypad_scanner.sv
bench/keypad_scan_checker.sv
bench/tb_matrix_keypad_scanner.sv
